FILE: design/psched_pkg.sv
package psched_pkg;

  localparam int ID_W = 8;
  localparam int PRIO_W = 8;
  localparam int BURST_W = 16;

  // One scheduler tick as presented on the input channel.
  typedef struct packed {
    logic              arrive;
    logic [ID_W-1:0]   process_id;
    logic [BURST_W-1:0] burst_time;
    logic [PRIO_W-1:0] priority_level;
  } tick_t;

  // Outcome of one tick.
  typedef struct packed {
    logic            busy_res;
    logic [ID_W-1:0] running_id;
    logic            done_res;
    logic            dropped;
  } result_t;

  // One ready-queue entry as held in the queue memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller sequence for one tick.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_SERVE,
    ST_POP,
    ST_RESULT
  } state_t;

endpackage

FILE: design/psched_ram.sv
module psched_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/psched_ctrl.sv
module psched_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick_valid,
  output logic                              tick_stall,
  input  psched_pkg::tick_t                 tick,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [psched_pkg::ENTRY_W-1:0]    ram_wdata,
  output logic [AW-1:0]                     ram_raddr,
  input  logic [psched_pkg::ENTRY_W-1:0]    ram_rdata,
  output logic                              res_valid,
  output psched_pkg::result_t               res,
  input  logic                              res_taken
);

  localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  // The head entry lives in registers; entries behind it sit in the memory
  // as a circular buffer that starts at rhead.
  psched_pkg::state_t state, state_next;
  psched_pkg::entry_t head, head_next;
  psched_pkg::entry_t arr, arr_next;
  psched_pkg::entry_t rd_entry;
  psched_pkg::result_t res_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] rhead, rhead_next;
  logic [AW-1:0] rhead_dec, rhead_inc;
  logic [AW-1:0] scan_k, scan_k_next;
  logic [AW-1:0] tail_k;

  // Physical slot of a queue position counted from the memory's front.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign rd_entry = psched_pkg::entry_t'(ram_rdata);
  assign rhead_dec = (rhead == '0) ? AW'(QUEUE_DEPTH - 1) : rhead - AW'(1);
  assign rhead_inc = (rhead == AW'(QUEUE_DEPTH - 1)) ? '0 : rhead + AW'(1);
  assign tail_k = AW'(count - CW'(2));

  // State and payload registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psched_pkg::ST_IDLE;
      count <= '0;
      rhead <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      rhead <= rhead_next;
    end
    head <= head_next;
    arr <= arr_next;
    scan_k <= scan_k_next;
    res <= res_next;
  end

  // Next state, memory accesses and the tick result.
  always_comb begin
    state_next = state;
    head_next = head;
    arr_next = arr;
    count_next = count;
    rhead_next = rhead;
    scan_k_next = scan_k;
    res_next = res;
    ram_we = 1'b0;
    ram_waddr = rhead;
    ram_wdata = arr;
    ram_raddr = rhead;
    tick_stall = 1'b1;
    res_valid = 1'b0;
    unique case (state)
      psched_pkg::ST_IDLE: begin
        tick_stall = 1'b0;
        if (tick_valid) begin
          res_next = '0;
          arr_next.id = tick.process_id;
          arr_next.prio = tick.priority_level;
          arr_next.remaining = tick.burst_time;
          state_next = psched_pkg::ST_SERVE;
          if (tick.arrive) begin
            priority if (count == FULL_COUNT) begin
              res_next.dropped = 1'b1;
            end else if (count == '0) begin
              head_next = arr_next;
              count_next = CW'(1);
            end else if (tick.priority_level < head.prio) begin
              // Preemption: the old head goes to the front of the memory.
              ram_we = 1'b1;
              ram_waddr = rhead_dec;
              ram_wdata = head;
              rhead_next = rhead_dec;
              head_next = arr_next;
              count_next = count + CW'(1);
            end else if (count == CW'(1)) begin
              ram_we = 1'b1;
              ram_waddr = rhead;
              ram_wdata = arr_next;
              count_next = count + CW'(1);
            end else begin
              // Walk back from the tail, shifting entries that must follow.
              scan_k_next = tail_k;
              ram_raddr = phys(rhead, tail_k);
              state_next = psched_pkg::ST_SCAN;
            end
          end
        end
      end
      psched_pkg::ST_SCAN: begin
        ram_we = 1'b1;
        ram_waddr = phys(rhead, scan_k + AW'(1));
        if (rd_entry.prio >= arr.prio) begin
          ram_wdata = rd_entry;
          if (scan_k == '0) begin
            state_next = psched_pkg::ST_PLACE;
          end else begin
            scan_k_next = scan_k - AW'(1);
            ram_raddr = phys(rhead, scan_k - AW'(1));
          end
        end else begin
          ram_wdata = arr;
          count_next = count + CW'(1);
          state_next = psched_pkg::ST_SERVE;
        end
      end
      psched_pkg::ST_PLACE: begin
        ram_we = 1'b1;
        ram_waddr = rhead;
        ram_wdata = arr;
        count_next = count + CW'(1);
        state_next = psched_pkg::ST_SERVE;
      end
      psched_pkg::ST_SERVE: begin
        state_next = psched_pkg::ST_RESULT;
        if (count != '0) begin
          res_next.busy_res = 1'b1;
          res_next.running_id = head.id;
          if (head.remaining <= psched_pkg::BURST_W'(1)) begin
            res_next.done_res = 1'b1;
            if (count == CW'(1)) begin
              count_next = '0;
            end else begin
              // Fetch the next head from the memory front.
              ram_raddr = rhead;
              state_next = psched_pkg::ST_POP;
            end
          end else begin
            head_next.remaining = head.remaining - psched_pkg::BURST_W'(1);
          end
        end
      end
      psched_pkg::ST_POP: begin
        head_next = rd_entry;
        rhead_next = rhead_inc;
        count_next = count - CW'(1);
        state_next = psched_pkg::ST_RESULT;
      end
      psched_pkg::ST_RESULT: begin
        res_valid = 1'b1;
        if (res_taken) begin
          state_next = psched_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psched_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler.
// Each input transaction on tick/tick_valid/tick_stall is one scheduler tick,
// optionally carrying an arriving process (id, burst time, priority; a lower
// number is more urgent). Each tick yields exactly one result transaction on
// result/result_valid/result_stall: whether a process ran, its id, whether it
// finished, and whether the arrival was dropped because the queue was full.
// The ready queue is kept in one memory as a circular buffer behind a head
// entry held in registers. Preemption and removal cost one memory access.
// An arrival that lands behind the head walks back from the tail, one entry
// per cycle, so the time from acceptance to the result is set by that walk.
// One tick is in flight at a time; tick_stall stays high until its result
// has moved to the output register. A stalled result holds in the output
// register while the next tick is already being worked on. Reset (rst,
// synchronous) empties the queue and clears both valid flags; the queue
// memory needs no clearing pass.
module preemptive_priority_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  psched_pkg::tick_t   tick,
  output logic                result_valid,
  input  logic                result_stall,
  output psched_pkg::result_t result
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [psched_pkg::ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [psched_pkg::ENTRY_W-1:0] ram_rdata;
  logic                           res_valid;
  logic                           res_taken;
  psched_pkg::result_t            res;

  psched_ram #(
    .WIDTH(psched_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  psched_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick      (tick),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  // The output register is free when empty or drained in this cycle.
  assign res_taken = !result_valid || !result_stall;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_taken) begin
      result_valid <= res_valid;
    end
    if (res_taken && res_valid) begin
      result <= res;
    end
  end

endmodule

FILE: test/preemptive_priority_scheduler_tb.sv
`timescale 1ns / 100ps

module preemptive_priority_scheduler_tb;

  localparam int QUEUE_DEPTH = 16;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_PHASES = 5;
  localparam int TICKS_PER_PHASE = 220;
  localparam int HOLD_CYCLES = 300;
  localparam logic EXP_TYPED = 1'b1;
  localparam logic EXP_MODEL = 1'b0;

  // One row of the directed table: the tick, and an outcome typed in by hand
  // where it is obvious, otherwise taken from the shadow queue.
  typedef struct packed {
    psched_pkg::tick_t   stim;
    logic                typed;
    psched_pkg::result_t outcome;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                tick_valid = 1'b0;
  logic                tick_stall;
  psched_pkg::tick_t   tick = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  psched_pkg::result_t result;

  // Shadow copy of the ready queue; entry 0 is the process being served.
  logic [psched_pkg::ID_W-1:0]    shadow_id [QUEUE_DEPTH];
  logic [psched_pkg::PRIO_W-1:0]  shadow_prio [QUEUE_DEPTH];
  logic [psched_pkg::BURST_W-1:0] shadow_remaining [QUEUE_DEPTH];
  int                             shadow_count = 0;

  psched_pkg::result_t pending_outcomes[$];
  directed_row_t       directed_rows [DIRECTED_ROWS];
  int                  mismatch_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  logic                hold_go = 1'b0;
  int                  hold_count = 0;

  preemptive_priority_scheduler #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick(tick),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #2 clk = ~clk;

  // Advance the shadow queue by one scheduler tick and return its outcome.
  function automatic psched_pkg::result_t schedule_tick(input psched_pkg::tick_t t);
    psched_pkg::result_t r;
    int                  pos;
    int                  k;
    r = '0;
    if (t.arrive) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        // Strictly more urgent preempts the head; ties queue behind it.
        if (shadow_count == 0 || t.priority_level < shadow_prio[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < shadow_count && shadow_prio[pos] < t.priority_level) pos++;
        end
        for (k = shadow_count; k > pos; k--) begin
          shadow_id[k] = shadow_id[k-1];
          shadow_prio[k] = shadow_prio[k-1];
          shadow_remaining[k] = shadow_remaining[k-1];
        end
        shadow_id[pos] = t.process_id;
        shadow_prio[pos] = t.priority_level;
        shadow_remaining[pos] = t.burst_time;
        shadow_count++;
      end
    end
    // Serve the head; a zero burst finishes like a burst of one.
    if (shadow_count > 0) begin
      r.busy_res = 1'b1;
      r.running_id = shadow_id[0];
      if (shadow_remaining[0] <= 1) begin
        r.done_res = 1'b1;
        for (k = 1; k < shadow_count; k++) begin
          shadow_id[k-1] = shadow_id[k];
          shadow_prio[k-1] = shadow_prio[k];
          shadow_remaining[k-1] = shadow_remaining[k];
        end
        shadow_count--;
      end else begin
        shadow_remaining[0] = shadow_remaining[0] - 1'b1;
      end
    end
    return r;
  endfunction

  // Random tick: small bursts mostly, with ties on urgent priorities.
  function automatic psched_pkg::tick_t random_tick(input int arrive_pct);
    psched_pkg::tick_t t;
    t.arrive = ($urandom_range(0, 99) < arrive_pct);
    t.process_id = psched_pkg::ID_W'($urandom_range(0, 255));
    if ($urandom_range(0, 127) == 0) begin
      t.burst_time = psched_pkg::BURST_W'($urandom_range(0, 200));
    end else begin
      t.burst_time = psched_pkg::BURST_W'($urandom_range(0, 6));
    end
    if ($urandom_range(0, 4) < 2) begin
      t.priority_level = psched_pkg::PRIO_W'($urandom_range(0, 3));
    end else begin
      t.priority_level = psched_pkg::PRIO_W'($urandom_range(0, 255));
    end
    return t;
  endfunction

  // Offer one tick and wait for its transaction; record the expected outcome.
  task automatic send_tick(input psched_pkg::tick_t t, input logic typed,
                           input psched_pkg::result_t given);
    psched_pkg::result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= t;
    do @(posedge clk); while (tick_stall);
    predicted = schedule_tick(t);
    pending_outcomes.push_back(typed ? given : predicted);
  endtask

  // Compare one accepted result with the oldest expected outcome.
  task automatic check_result(input psched_pkg::result_t got);
    psched_pkg::result_t want;
    if (pending_outcomes.size() == 0) begin
      $error("unexpected result: busy_res=%0b running_id=%0h done_res=%0b dropped=%0b",
             got.busy_res, got.running_id, got.done_res, got.dropped);
      mismatch_count++;
    end else begin
      want = pending_outcomes.pop_front();
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
        mismatch_count++;
      end
      if (got.running_id !== want.running_id) begin
        $error("running_id: expected %0h, got %0h", want.running_id, got.running_id);
        mismatch_count++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
        mismatch_count++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
        mismatch_count++;
      end
    end
  endtask

  // Result side: check each transaction, then choose the next stall.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result(result);
      end
      if (hold_go && hold_count < HOLD_CYCLES) begin
        result_stall <= 1'b1;
        hold_count <= hold_count + 1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Stimulus: directed table, then random phases with different idling.
  initial begin
    int row;
    int phase;
    int n;
    int arrive_pct;
    directed_rows = '{
      // Empty queue after reset gives an idle result.
      {1'b0, 8'h00, 16'h0000, 8'h00, EXP_TYPED, 1'b0, 8'h00, 1'b0, 1'b0},
      // Zero burst finishes on its first tick; extreme ids and priorities.
      {1'b1, 8'hFF, 16'h0000, 8'hFF, EXP_TYPED, 1'b1, 8'hFF, 1'b1, 1'b0},
      {1'b1, 8'h00, 16'h0001, 8'h00, EXP_TYPED, 1'b1, 8'h00, 1'b1, 1'b0},
      // Long low-urgency job, then preemption and equal-priority arrivals.
      {1'b1, 8'hA5, 16'h0100, 8'hFE, EXP_MODEL, 11'h000},
      {1'b1, 8'h5A, 16'h0003, 8'h10, EXP_MODEL, 11'h000},
      {1'b1, 8'h11, 16'h0002, 8'h10, EXP_MODEL, 11'h000},
      {1'b1, 8'h22, 16'h0001, 8'h01, EXP_MODEL, 11'h000},
      // No arrival: the identity fields must be ignored.
      {1'b0, 8'hFF, 16'hFFFF, 8'hFF, EXP_MODEL, 11'h000},
      {1'b1, 8'h33, 16'h0002, 8'h10, EXP_MODEL, 11'h000},
      // Fill the queue to capacity.
      {1'b1, 8'h40, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h41, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h42, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h43, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h44, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h45, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h46, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h47, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h48, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h49, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h4A, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h4B, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h4C, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h4D, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      {1'b1, 8'h4E, 16'h0014, 8'h80, EXP_MODEL, 11'h000},
      // Full queue: the arrival is dropped while the head is still served.
      {1'b1, 8'hFF, 16'hFFFF, 8'h00, EXP_TYPED, 1'b1, 8'h42, 1'b0, 1'b1}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_tick(directed_rows[row].stim, directed_rows[row].typed,
                directed_rows[row].outcome);
    end

    arrive_pct = 50;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        3: begin send_idle_pct = 27; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // Long receiver hold while ticks keep coming, so the input backs up.
      if (phase == 0) hold_go <= 1'b1;
      for (n = 0; n < TICKS_PER_PHASE; n++) begin
        // Vary the load so the queue both fills up and drains empty.
        if (n % 50 == 0) begin
          case ($urandom_range(0, 3))
            0: arrive_pct = 10;
            1: arrive_pct = 30;
            2: arrive_pct = 60;
            default: arrive_pct = 95;
          endcase
        end
        send_tick(random_tick(arrive_pct), EXP_MODEL, '0);
      end
    end
    tick_valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4 * QUEUE_DEPTH) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
